// ===== rtl/bgi_pkg.sv =====
// Shared constants and register codes for the bilinear grid interpolator.
package bgi_pkg;

  localparam int unsigned MAX_DIM    = 256;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned DIM_W      = $clog2(MAX_DIM);
  localparam int unsigned DIM_CNT_W  = DIM_W + 1;
  localparam int unsigned HALF_W     = DIM_W - 1;
  localparam int unsigned BANK_AW    = 2 * HALF_W;
  localparam int unsigned BANK_DEPTH = (MAX_DIM * MAX_DIM) / 4;
  localparam int unsigned NUM_BANKS  = 4;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned WEIGHT_W = FRAC_W + 1 + FRAC_W;  // up to 2^32
  localparam int unsigned PROD_W   = SAMPLE_W + WEIGHT_W;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned ACC_W    = PROD_W + 2;
  localparam int unsigned VALUE_W  = 25;

  // s_axis tdata layout, lowest bits first
  localparam int unsigned QX_LSB     = 0;
  localparam int unsigned QY_LSB     = QX_LSB + COORD_W;
  localparam int unsigned WCOL_LSB   = QY_LSB + COORD_W;
  localparam int unsigned WROW_LSB   = WCOL_LSB + DIM_W;
  localparam int unsigned WVAL_LSB   = WROW_LSB + DIM_W;
  localparam int unsigned IN_USED_W  = WVAL_LSB + VALUE_W;
  localparam int unsigned IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [COORD_W-1:0]   RST_INV_SPACING = 32'h0001_0000;
  localparam logic [DIM_CNT_W-1:0] RST_DIM_COUNT   = DIM_CNT_W'(MAX_DIM);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_INV_SPACING_X = 3'd2,
    CFG_INV_SPACING_Y = 3'd3,
    CFG_COLS_IN_USE   = 3'd4,
    CFG_ROWS_IN_USE   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

endpackage

// ===== rtl/bgi_sample_ram.sv =====
// Simple dual-port sample RAM: one write and one registered read per cycle.
module bgi_sample_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bilinear_grid_interpolator_unit.sv =====
// Top level: bilinear interpolation over a 2-D sample grid held in four banked RAMs.
// Takes one item per cycle except while the skid stage holds a result.
// A write goes into its bank from stage 2, so a query that follows it sees it.
// The four corner reads come from four RAMs banked by column and row parity.
// An output register plus a skid stage decouple the pipeline from m_axis backpressure.
// Reset loads config defaults, clears pipeline valids; grid contents are undefined until written.
module bilinear_grid_interpolator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // query_x, query_y, write_col, write_row, write_value, zero pad
  input  logic [bgi_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // mode
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // density
  output logic [bgi_pkg::SAMPLE_W-1:0]        m_axis_tdata_o,
  // inside_res
  output logic                                m_axis_tuser_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bgi_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import bgi_pkg::*;

  // configuration
  logic [COORD_W-1:0]   origin_x_q, origin_y_q, inv_x_q, inv_y_q;
  logic [DIM_CNT_W-1:0] cols_q, rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_x_q    <= RST_INV_SPACING;
      inv_y_q    <= RST_INV_SPACING;
      cols_q     <= RST_DIM_COUNT;
      rows_q     <= RST_DIM_COUNT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X:      origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y:      origin_y_q <= cfg_data_i;
        CFG_INV_SPACING_X: inv_x_q    <= cfg_data_i;
        CFG_INV_SPACING_Y: inv_y_q    <= cfg_data_i;
        CFG_COLS_IN_USE:   cols_q     <= cfg_data_i[DIM_CNT_W-1:0];
        CFG_ROWS_IN_USE:   rows_q     <= cfg_data_i[DIM_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic skid_valid_q;
  logic advance;
  logic in_xfer;

  assign advance         = ~skid_valid_q;
  assign s_axis_tready_o = advance;
  assign in_xfer         = s_axis_tvalid_i & advance;

  // stage 1: offsets from origin
  logic [COORD_W-1:0] qx, qy;
  logic [DIM_W-1:0]   wcol, wrow;
  logic [VALUE_W-1:0] wval;
  logic [COORD_W:0]   dx_d, dy_d;
  logic [SAMPLE_W-1:0] wsample_d;

  assign qx   = s_axis_tdata_i[QX_LSB +: COORD_W];
  assign qy   = s_axis_tdata_i[QY_LSB +: COORD_W];
  assign wcol = s_axis_tdata_i[WCOL_LSB +: DIM_W];
  assign wrow = s_axis_tdata_i[WROW_LSB +: DIM_W];
  assign wval = s_axis_tdata_i[WVAL_LSB +: VALUE_W];

  assign dx_d = {qx[COORD_W-1], qx} - {origin_x_q[COORD_W-1], origin_x_q};
  assign dy_d = {qy[COORD_W-1], qy} - {origin_y_q[COORD_W-1], origin_y_q};
  // negative samples clamp to zero
  assign wsample_d = wval[VALUE_W-1] ? '0 : wval[SAMPLE_W-1:0];

  logic                s1_valid_q, s1_mode_q;
  logic [COORD_W:0]    s1_dx_q, s1_dy_q;
  logic [DIM_W-1:0]    s1_wcol_q, s1_wrow_q;
  logic [SAMPLE_W-1:0] s1_wsample_q;

  // stage 2: scale by reciprocal spacing, Q32.32 cell position
  logic [COORD_W-1:0]   opx, opy;
  logic [2*COORD_W-1:0] px_d, py_d;
  logic                 negx_d, negy_d;

  assign opx    = s1_dx_q[COORD_W] ? '0 : s1_dx_q[COORD_W-1:0];
  assign opy    = s1_dy_q[COORD_W] ? '0 : s1_dy_q[COORD_W-1:0];
  assign px_d   = {{COORD_W{1'b0}}, opx} * {{COORD_W{1'b0}}, inv_x_q};
  assign py_d   = {{COORD_W{1'b0}}, opy} * {{COORD_W{1'b0}}, inv_y_q};
  assign negx_d = s1_dx_q[COORD_W] & (inv_x_q != '0);
  assign negy_d = s1_dy_q[COORD_W] & (inv_y_q != '0);

  logic                 s2_valid_q, s2_mode_q, s2_negx_q, s2_negy_q;
  logic [2*COORD_W-1:0] s2_px_q, s2_py_q;
  logic [DIM_W-1:0]     s2_wcol_q, s2_wrow_q;
  logic [SAMPLE_W-1:0]  s2_wsample_q;

  // stage 3: cell bounds, weights, RAM access
  logic [COORD_W-1:0]   cellx, celly;
  logic [DIM_W-1:0]     ix, iy;
  logic [FRAC_W-1:0]    fx, fy;
  logic [FRAC_W:0]      gx, gy;
  logic [DIM_CNT_W-1:0] limx, limy;
  logic                 inside_d;
  logic [WEIGHT_W-1:0]  w00_d, w10_d, w01_d, w11_d;
  logic [2*FRAC_W+1:0]  gg_full;

  assign cellx = s2_px_q[2*COORD_W-1:COORD_W];
  assign celly = s2_py_q[2*COORD_W-1:COORD_W];
  assign ix    = cellx[DIM_W-1:0];
  assign iy    = celly[DIM_W-1:0];
  assign fx    = s2_px_q[COORD_W-1 -: FRAC_W];
  assign fy    = s2_py_q[COORD_W-1 -: FRAC_W];
  assign limx  = (cols_q > RST_DIM_COUNT) ? RST_DIM_COUNT : cols_q;
  assign limy  = (rows_q > RST_DIM_COUNT) ? RST_DIM_COUNT : rows_q;

  // last full cell: index + 2 must not pass the count in use
  assign inside_d = ~s2_negx_q & ~s2_negy_q
                  & (cellx[COORD_W-1:DIM_W] == '0) & (celly[COORD_W-1:DIM_W] == '0)
                  & (({2'b00, ix} + (DIM_W+2)'(2)) <= {1'b0, limx})
                  & (({2'b00, iy} + (DIM_W+2)'(2)) <= {1'b0, limy});

  assign gx = {1'b1, {FRAC_W{1'b0}}} - {1'b0, fx};
  assign gy = {1'b1, {FRAC_W{1'b0}}} - {1'b0, fy};

  assign gg_full = gx * gy;
  assign w00_d   = gg_full[WEIGHT_W-1:0];
  assign w10_d   = {{(FRAC_W+1){1'b0}}, fx} * {{FRAC_W{1'b0}}, gy};
  assign w01_d   = {{FRAC_W{1'b0}}, gx} * {{(FRAC_W+1){1'b0}}, fy};
  assign w11_d   = {{(FRAC_W+1){1'b0}}, fx} * {{(FRAC_W+1){1'b0}}, fy};

  // bank {col parity, row parity}; bank with parity p holds whichever of i, i+1 has it
  logic [HALF_W-1:0] colhalf [2];
  logic [HALF_W-1:0] rowhalf [2];

  assign colhalf[0] = ix[DIM_W-1:1] + HALF_W'(ix[0]);
  assign colhalf[1] = ix[DIM_W-1:1];
  assign rowhalf[0] = iy[DIM_W-1:1] + HALF_W'(iy[0]);
  assign rowhalf[1] = iy[DIM_W-1:1];

  logic                re_all;
  logic                we_any;
  logic [BANK_AW-1:0]  waddr;
  logic [SAMPLE_W-1:0] bank_rdata [NUM_BANKS];

  assign re_all = advance & s2_valid_q & (s2_mode_q == MODE_QUERY);
  assign we_any = advance & s2_valid_q & (s2_mode_q == MODE_WRITE);
  assign waddr  = {s2_wcol_q[DIM_W-1:1], s2_wrow_q[DIM_W-1:1]};

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [1:0] bank_id;
    assign bank_id = 2'(b);

    bgi_sample_ram #(
      .DEPTH (BANK_DEPTH),
      .WIDTH (SAMPLE_W)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we_any & ({s2_wcol_q[0], s2_wrow_q[0]} == bank_id)),
      .waddr_i (waddr),
      .wdata_i (s2_wsample_q),
      .re_i    (re_all),
      .raddr_i ({colhalf[bank_id[1]], rowhalf[bank_id[0]]}),
      .rdata_o (bank_rdata[b])
    );
  end

  logic                s3_valid_q, s3_inside_q, s3_ixp_q, s3_iyp_q;
  logic [WEIGHT_W-1:0] s3_w00_q, s3_w10_q, s3_w01_q, s3_w11_q;

  // stage 4: corner products
  logic [SAMPLE_W-1:0] c00, c10, c01, c11;
  logic [PROD_W-1:0]   p00_d, p10_d, p01_d, p11_d;

  assign c00 = bank_rdata[{s3_ixp_q,         s3_iyp_q}];
  assign c10 = bank_rdata[{~s3_ixp_q,        s3_iyp_q}];
  assign c01 = bank_rdata[{s3_ixp_q,        ~s3_iyp_q}];
  assign c11 = bank_rdata[{~s3_ixp_q,       ~s3_iyp_q}];

  assign p00_d = {{WEIGHT_W{1'b0}}, c00} * {{SAMPLE_W{1'b0}}, s3_w00_q};
  assign p10_d = {{WEIGHT_W{1'b0}}, c10} * {{SAMPLE_W{1'b0}}, s3_w10_q};
  assign p01_d = {{WEIGHT_W{1'b0}}, c01} * {{SAMPLE_W{1'b0}}, s3_w01_q};
  assign p11_d = {{WEIGHT_W{1'b0}}, c11} * {{SAMPLE_W{1'b0}}, s3_w11_q};

  logic              s4_valid_q, s4_inside_q;
  logic [PROD_W-1:0] s4_p00_q, s4_p10_q, s4_p01_q, s4_p11_q;

  // stage 5: pair sums
  logic [SUM_W-1:0] sa_d, sb_d;
  assign sa_d = {1'b0, s4_p00_q} + {1'b0, s4_p10_q};
  assign sb_d = {1'b0, s4_p01_q} + {1'b0, s4_p11_q};

  logic             s5_valid_q, s5_inside_q;
  logic [SUM_W-1:0] s5_sa_q, s5_sb_q;

  // final sum, truncated to sample scale; zero when outside the grid
  logic [ACC_W-1:0]    acc;
  logic [SAMPLE_W-1:0] res_density;

  assign acc         = {1'b0, s5_sa_q} + {1'b0, s5_sb_q};
  assign res_density = s5_inside_q ? acc[2*FRAC_W +: SAMPLE_W] : '0;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s_axis_tvalid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= re_all;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_mode_q    <= s_axis_tuser_i;
      s1_dx_q      <= dx_d;
      s1_dy_q      <= dy_d;
      s1_wcol_q    <= wcol;
      s1_wrow_q    <= wrow;
      s1_wsample_q <= wsample_d;
    end
    if (advance) begin
      s2_mode_q    <= s1_mode_q;
      s2_px_q      <= px_d;
      s2_py_q      <= py_d;
      s2_negx_q    <= negx_d;
      s2_negy_q    <= negy_d;
      s2_wcol_q    <= s1_wcol_q;
      s2_wrow_q    <= s1_wrow_q;
      s2_wsample_q <= s1_wsample_q;

      s3_inside_q  <= inside_d;
      s3_ixp_q     <= ix[0];
      s3_iyp_q     <= iy[0];
      s3_w00_q     <= w00_d;
      s3_w10_q     <= w10_d;
      s3_w01_q     <= w01_d;
      s3_w11_q     <= w11_d;

      s4_inside_q  <= s3_inside_q;
      s4_p00_q     <= p00_d;
      s4_p10_q     <= p10_d;
      s4_p01_q     <= p01_d;
      s4_p11_q     <= p11_d;

      s5_inside_q  <= s4_inside_q;
      s5_sa_q      <= sa_d;
      s5_sb_q      <= sb_d;
    end
  end

  // output register and skid stage
  logic                out_valid_q, out_inside_q, skid_inside_q;
  logic [SAMPLE_W-1:0] out_density_q, skid_density_q;
  logic                out_free;
  logic                res_valid;

  assign out_free  = ~out_valid_q | m_axis_tready_i;
  assign res_valid = advance & s5_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_density_q <= skid_density_q;
        out_inside_q  <= skid_inside_q;
      end else begin
        out_density_q <= res_density;
        out_inside_q  <= s5_inside_q;
      end
    end else if (res_valid) begin
      skid_density_q <= res_density;
      skid_inside_q  <= s5_inside_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_density_q;
  assign m_axis_tuser_o  = out_inside_q;

endmodule
